>>> rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg: shared definitions for the reader/writer admission block
// sizes, codes and the command and status bundles between control and datapath
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_READERS = 255;
  localparam int MAX_RESULTS = 16;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int HOLD_W = $clog2(MAX_READERS + 1) + 1;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);
  localparam int ID_W   = 8;

  // input modes
  localparam logic [1:0] MODE_SUBMIT   = 2'd0;
  localparam logic [1:0] MODE_COMPLETE = 2'd1;
  localparam logic [1:0] MODE_READY    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_STARTED = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic capture;
    logic set_ready;
    logic submit;
    logic release_lock;
    logic walk;
  } fra_cmd_t;

  typedef struct packed {
    logic walk_go;
  } fra_stat_t;

endpackage

>>> rtl/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl: admission sequencer
// steps a submit, or a release followed by the walk over the queue head
// ----------------------------------------------------------------------------
module fra_ctrl
  import fra_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] mode_i,
  input  fra_stat_t  stat_i,
  output fra_cmd_t   cmd_o,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUBMIT,
    S_RELEASE,
    S_WALK
  } state_e;

  state_e state_q;
  logic   take;

  assign busy = (state_q != S_IDLE);
  assign take = start && (state_q == S_IDLE);

  always_comb begin
    cmd_o              = '0;
    cmd_o.capture      = take;
    cmd_o.set_ready    = take && (mode_i == MODE_READY);
    cmd_o.submit       = (state_q == S_SUBMIT);
    cmd_o.release_lock = (state_q == S_RELEASE);
    cmd_o.walk         = (state_q == S_WALK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (take) begin
            case (mode_i)
              MODE_SUBMIT:   state_q <= S_SUBMIT;
              MODE_COMPLETE: state_q <= S_RELEASE;
              default:       state_q <= S_IDLE;
            endcase
          end
        end
        S_SUBMIT:  state_q <= S_IDLE;
        S_RELEASE: state_q <= S_WALK;
        S_WALK: begin
          if (!stat_i.walk_go) state_q <= S_IDLE;
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/fra_dp.sv
// ----------------------------------------------------------------------------
// fra_dp: admission datapath
// request queue, holder count, ready flag and the registered result port
// ----------------------------------------------------------------------------
module fra_dp
  import fra_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fra_cmd_t        cmd_i,
  input  logic [ID_W-1:0] request_id_i,
  input  logic            is_write_i,
  input  logic            is_load_i,
  input  logic            is_data_i,
  output fra_stat_t       stat_o,
  output logic            strobe_o,
  output logic [ID_W-1:0] grant_id_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  localparam logic signed [HOLD_W-1:0] HOLD_ZERO = '0;
  localparam logic signed [HOLD_W-1:0] HOLD_ONE  = HOLD_W'(1);
  localparam logic signed [HOLD_W-1:0] HOLD_NEG  = '1;
  localparam logic signed [HOLD_W-1:0] HOLD_MAX  = HOLD_W'(MAX_READERS);
  localparam logic [PTR_W-1:0]         PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]         CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [NRES_W-1:0]        NRES_MAX  = NRES_W'(MAX_RESULTS);

  // queue storage
  logic [ID_W-1:0] id_mem   [QUEUE_DEPTH];
  logic            wr_mem   [QUEUE_DEPTH];
  logic            data_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [HOLD_W-1:0] holder_q, holder_d;
  logic                     ready_q, ready_d;
  logic [NRES_W-1:0]        nres_q, nres_d;
  logic                     pend_vld_q, pend_vld_d;
  logic [ID_W-1:0]          pend_id_q, pend_id_d;
  logic                     strobe_q, strobe_d;
  logic [ID_W-1:0]          out_id_q, out_id_d;
  logic [1:0]               out_st_q, out_st_d;
  logic                     out_last_q, out_last_d;

  // latched request fields
  logic [ID_W-1:0] req_id_q;
  logic            req_wr_q, req_load_q, req_data_q;

  logic            wr_en;
  logic            head_wr, head_data, reader_ok, start_ok, go;
  logic [ID_W-1:0] head_id;

  assign head_id   = id_mem[head_q];
  assign head_wr   = wr_mem[head_q];
  assign head_data = data_mem[head_q];
  assign reader_ok = (holder_q >= HOLD_ZERO) && (holder_q < HOLD_MAX);

  always_comb begin
    if (ready_q) begin
      start_ok = (count_q == '0) && (req_wr_q ? (holder_q == HOLD_ZERO) : reader_ok);
      go = (count_q != '0) &&
           (head_wr ? (holder_q == HOLD_ZERO) : (reader_ok && (nres_q < NRES_MAX)));
    end else begin
      start_ok = (count_q == '0) && req_load_q;
      go       = (count_q != '0) && !head_data && (nres_q == '0);
    end
  end

  assign stat_o.walk_go = go;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    holder_d   = holder_q;
    ready_d    = ready_q;
    nres_d     = nres_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    strobe_d   = 1'b0;
    out_id_d   = out_id_q;
    out_st_d   = out_st_q;
    out_last_d = out_last_q;
    wr_en      = 1'b0;

    if (cmd_i.set_ready) ready_d = 1'b1;

    if (cmd_i.submit) begin
      strobe_d   = 1'b1;
      out_id_d   = req_id_q;
      out_last_d = 1'b1;
      if (start_ok) begin
        out_st_d = ST_STARTED;
        holder_d = (ready_q && !req_wr_q) ? holder_q + HOLD_ONE : HOLD_NEG;
      end else if (count_q == CNT_FULL) begin
        out_st_d = ST_DROPPED;
      end else begin
        out_st_d = ST_QUEUED;
        wr_en    = 1'b1;
        tail_d   = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
        count_d  = count_q + CNT_W'(1);
      end
    end

    if (cmd_i.release_lock) begin
      nres_d     = '0;
      pend_vld_d = 1'b0;
      if (ready_q) holder_d = (holder_q <= HOLD_ZERO) ? HOLD_ZERO : holder_q - HOLD_ONE;
    end

    // one start per cycle, held in the pending register so that the final one carries last
    if (cmd_i.walk) begin
      if (go) begin
        if (pend_vld_q) begin
          strobe_d   = 1'b1;
          out_id_d   = pend_id_q;
          out_st_d   = ST_STARTED;
          out_last_d = 1'b0;
        end
        pend_vld_d = 1'b1;
        pend_id_d  = head_id;
        head_d     = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
        count_d    = count_q - CNT_W'(1);
        nres_d     = nres_q + NRES_W'(1);
        if (ready_q) holder_d = head_wr ? HOLD_NEG : holder_q + HOLD_ONE;
      end else if (pend_vld_q) begin
        strobe_d   = 1'b1;
        out_id_d   = pend_id_q;
        out_st_d   = ST_STARTED;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      holder_q   <= '0;
      ready_q    <= 1'b0;
      nres_q     <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      holder_q   <= holder_d;
      ready_q    <= ready_d;
      nres_q     <= nres_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    out_id_q   <= out_id_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
    if (cmd_i.capture) begin
      req_id_q   <= request_id_i;
      req_wr_q   <= is_write_i;
      req_load_q <= is_load_i;
      req_data_q <= is_data_i;
    end
    if (wr_en) begin
      id_mem[tail_q]   <= req_id_q;
      wr_mem[tail_q]   <= req_wr_q;
      data_mem[tail_q] <= req_data_q;
    end
  end

  assign strobe_o   = strobe_q;
  assign grant_id_o = out_id_q;
  assign status_o   = out_st_q;
  assign last_o     = out_last_q;

endmodule

>>> rtl/fifo_reader_writer_admission.sv
// ----------------------------------------------------------------------------
// fifo_reader_writer_admission: fifo-ordered reader/writer lock admission
// decides when submitted requests to a shared table start, queue or drop
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A submit is busy for
// its submit step alone and its single result appears on the cycle after that
// step, with busy already low again. A completion is busy for a release step,
// a walk step for each request started from the queue head and a closing walk
// step, with at most 16 starts; each start passes through the pending register
// and then the result register, one a cycle, and the final one, flagged by
// last, appears as busy falls. Make ready gives no result, as does the unused
// mode. The walk over the queue head, one dequeue a cycle, sets the completion
// time. Results last exactly one cycle on strobe_o and cannot be held off; no
// reset sweep is needed.
// ----------------------------------------------------------------------------
module fifo_reader_writer_admission
  import fra_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      mode_i,
  input  logic [ID_W-1:0] request_id_i,
  input  logic            is_write_i,
  input  logic            is_load_i,
  input  logic            is_data_i,
  output logic            strobe_o,
  output logic [ID_W-1:0] grant_id_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  fra_cmd_t  cmd;
  fra_stat_t stat;

  // sequencer: which step of the command runs this cycle
  fra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // queue, lock state and result register
  fra_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .request_id_i (request_id_i),
    .is_write_i   (is_write_i),
    .is_load_i    (is_load_i),
    .is_data_i    (is_data_i),
    .stat_o       (stat),
    .strobe_o     (strobe_o),
    .grant_id_o   (grant_id_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

`ifndef NO_ASSERTIONS
  // a submit transfer raises busy, then yields a closing result
  a_submit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_SUBMIT) |=> busy ##1 (strobe_o && last_o))
    else $error("submit did not produce its result");

  // make ready leaves busy low and gives no result
  a_ready_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_READY) |=> (!busy && !strobe_o))
    else $error("make ready left the block busy or gave a result");

  // queued and dropped only come from a submit, which always closes
  a_nonstart_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o != ST_STARTED) |-> last_o)
    else $error("non-start result without last");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fifo-ordered reader/writer admission
// drives submits, completions and make-ready commands through the start/busy
// handshake, predicts every start, queue and drop decision, and checks each
// strobed result in order against the prediction
// ----------------------------------------------------------------------------
module tb_top;
  import fra_pkg::*;

  // the fourth mode value has no meaning and is simply ignored by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 40;    // idle wait after the bench has drained
  localparam int RANDOM_ITEMS = 50;
  localparam int PRINT_CAP    = 50;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [1:0]      mode_i;
  logic [ID_W-1:0] request_id_i;
  logic            is_write_i;
  logic            is_load_i;
  logic            is_data_i;
  logic            strobe_o;
  logic [ID_W-1:0] grant_id_o;
  logic [1:0]      status_o;
  logic            last_o;

  // one waiting request in the admission fifo
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            wr;
    logic            dq;
  } waiter_t;

  // one result as the block should strobe it
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      status;
    logic            last;
  } grant_t;

  // shadow of the lock state
  waiter_t                  waiters[$];
  logic signed [HOLD_W-1:0] holders;
  bit                       table_open;

  // results still owed by the block, oldest first
  grant_t grants_due[$];

  int fault_count;
  int stall_cycles;
  bit gaps_on;

  fifo_reader_writer_admission DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .request_id_i (request_id_i),
    .is_write_i   (is_write_i),
    .is_load_i    (is_load_i),
    .is_data_i    (is_data_i),
    .strobe_o     (strobe_o),
    .grant_id_o   (grant_id_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // admission predictor: applies one accepted command to the shadow state and
  // queues the results it should cause
  // --------------------------------------------------------------------------
  function automatic void admit_item(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                     input logic wr, input logic ld, input logic dq);
    grant_t    found[$];
    waiter_t   head;
    grant_t    one;
    bit        go;
    logic [1:0] st;
    case (mode)
      MODE_SUBMIT: begin
        go = 1'b0;
        // only an empty fifo lets a request jump straight onto the lock
        if (waiters.size() == 0) begin
          if (table_open) begin
            if (wr) begin
              if (holders == 0) begin
                holders = '1;
                go = 1'b1;
              end
            end else if (holders >= 0 && holders < MAX_READERS) begin
              holders = holders + HOLD_W'(1);
              go = 1'b1;
            end
          end else if (ld) begin
            // before the table is ready only a load may take the lock
            holders = '1;
            go = 1'b1;
          end
        end
        if (go) begin
          st = ST_STARTED;
        end else if (waiters.size() >= QUEUE_DEPTH) begin
          st = ST_DROPPED;
        end else begin
          waiters.insert(waiters.size(), '{id: id, wr: wr, dq: dq});
          st = ST_QUEUED;
        end
        found.insert(found.size(), '{id: id, status: st, last: 1'b0});
      end
      MODE_COMPLETE: begin
        if (table_open) begin
          // release first, then hand over to the head of the fifo
          if (holders <= 0) holders = '0;
          else holders = holders - HOLD_W'(1);
          if (waiters.size() > 0 && holders == 0 && waiters[0].wr) begin
            holders = '1;
            head = waiters[0];
            waiters.delete(0);
            found.insert(found.size(), '{id: head.id, status: ST_STARTED, last: 1'b0});
          end else begin
            // run of readers, bounded by the reader limit and the result cap
            while (waiters.size() > 0 && !waiters[0].wr && holders >= 0 &&
                   holders < MAX_READERS && found.size() < MAX_RESULTS) begin
              holders = holders + HOLD_W'(1);
              head = waiters[0];
              waiters.delete(0);
              found.insert(found.size(), '{id: head.id, status: ST_STARTED, last: 1'b0});
            end
          end
        end else if (waiters.size() > 0 && !waiters[0].dq) begin
          // not ready: a non-data head starts, lock count left alone
          head = waiters[0];
          waiters.delete(0);
          found.insert(found.size(), '{id: head.id, status: ST_STARTED, last: 1'b0});
        end
      end
      MODE_READY: table_open = 1'b1;
      default: ;
    endcase
    foreach (found[k]) begin
      one = '{id: found[k].id, status: found[k].status, last: (k == found.size() - 1)};
      grants_due.insert(grants_due.size(), one);
    end
  endfunction

  // --------------------------------------------------------------------------
  // one command transfer; entered and left at a rising edge, never lowers
  // start at the end so back-to-back transfers keep it high
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] mode, input logic [ID_W-1:0] id,
                           input logic wr, input logic ld, input logic dq);
    bit taken;
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= mode;
    request_id_i <= id;
    is_write_i   <= wr;
    is_load_i    <= ld;
    is_data_i    <= dq;
    taken = 1'b0;
    // busy is sampled mid-cycle, where it holds the value the next edge sees
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    admit_item(mode, id, wr, ld, dq);
  endtask

  task automatic send_random_submit(input int write_pct);
    send_item(MODE_SUBMIT, ID_W'($urandom_range(0, 255)), $urandom_range(0, 99) < write_pct,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_complete();
    send_item(MODE_COMPLETE, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // hold the sender off until every owed result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (grants_due.size() != 0) @(posedge clk_i);
  endtask

  // complete until the fifo is empty and nobody holds the lock (ready mode only)
  task automatic release_lock_fully();
    while (waiters.size() != 0 || holders != 0) send_random_complete();
  endtask

  task automatic flag_mismatch(input string what);
    if (fault_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    fault_count++;
  endtask

  // --------------------------------------------------------------------------
  // result checker: each strobe is one transfer and cannot be held off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : grant_check
    grant_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (grants_due.size() == 0) begin
        flag_mismatch($sformatf("result id %02h status %0d with none owed",
                                grant_id_o, status_o));
      end else begin
        want = grants_due[0];
        grants_due.delete(0);
        if (grant_id_o !== want.id)
          flag_mismatch($sformatf("grant_id %02h, predicted %02h", grant_id_o, want.id));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d for id %02h, predicted %0d",
                                  status_o, want.id, want.status));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %0b for id %02h, predicted %0b",
                                  last_o, want.id, want.last));
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // not-ready behaviour: load start, queueing, non-data head start, data head
  // blocking, ignored mode, then make ready
  task automatic test_before_ready();
    send_item(MODE_SUBMIT, 8'hA5, 1'b1, 1'b1, 1'b0);   // load on empty fifo starts
    send_item(MODE_SUBMIT, 8'h5A, 1'b1, 1'b0, 1'b0);   // plain writer queued
    send_item(MODE_SUBMIT, 8'h00, 1'b0, 1'b0, 1'b1);   // data query queued
    send_item(MODE_SUBMIT, 8'hFF, 1'b1, 1'b1, 1'b0);   // load behind others queued
    send_item(MODE_COMPLETE, 8'h00, 1'b0, 1'b0, 1'b0); // non-data head starts
    send_item(MODE_COMPLETE, 8'hFF, 1'b1, 1'b1, 1'b1); // data query at head blocks
    send_item(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);   // ignored
    send_item(MODE_READY, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // ready mode: lock handover between readers and writers in fifo order
  task automatic test_lock_handover();
    send_item(MODE_COMPLETE, 8'h11, 1'b0, 1'b0, 1'b0); // reader run stops at writer
    send_item(MODE_COMPLETE, 8'h22, 1'b0, 1'b0, 1'b0); // writer takes the lock
    send_item(MODE_SUBMIT, 8'h3C, 1'b0, 1'b0, 1'b1);   // reader behind writer
    send_item(MODE_SUBMIT, 8'hC3, 1'b1, 1'b0, 1'b0);   // writer behind writer
    send_item(MODE_COMPLETE, 8'h44, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SUBMIT, 8'h81, 1'b0, 1'b1, 1'b0);   // reader behind fifo content
    send_item(MODE_COMPLETE, 8'h55, 1'b0, 1'b0, 1'b0);
    send_item(MODE_COMPLETE, 8'h66, 1'b0, 1'b0, 1'b0);
    send_item(MODE_SUBMIT, 8'h7E, 1'b0, 1'b0, 1'b0);   // shares with a reader
    send_item(MODE_SUBMIT, 8'h18, 1'b1, 1'b0, 1'b1);   // writer waits for readers
    send_item(MODE_COMPLETE, 8'h77, 1'b0, 1'b0, 1'b0); // one reader left, no start
    send_item(MODE_COMPLETE, 8'h88, 1'b0, 1'b0, 1'b0); // writer starts
    send_item(MODE_COMPLETE, 8'h99, 1'b0, 1'b0, 1'b0); // nothing waiting
    send_item(MODE_SUBMIT, 8'hE7, 1'b1, 1'b1, 1'b1);   // writer on a free lock
    // pause the sender until all owed results are in
    wait_drained();
  endtask

  // fill the fifo behind a writer, drop on overflow, then a full reader walk
  task automatic test_queue_full();
    release_lock_fully();
    send_random_submit(100);
    repeat (QUEUE_DEPTH + 1) send_random_submit(0);
    send_random_submit(100);
    send_random_complete();
    wait_drained();
  endtask

  // drive the reader count to its limit with no gaps on the sender side,
  // leaving a writer queued behind the readers at the end
  task automatic test_reader_limit();
    release_lock_fully();
    gaps_on = 1'b0;
    repeat (MAX_READERS + 3) send_random_submit(0);
    repeat (4) send_random_complete();
    send_random_submit(0);
    send_random_submit(100);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // bursts of submits followed by bursts of completions, with some noise
  task automatic test_random_traffic();
    int  sent;
    int  burst;
    bit  paused;
    logic [1:0] noise_mode;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      // a long stretch in the middle with no random gaps on the sender side
      gaps_on = !(sent >= 15 && sent < 35);
      if (!paused && sent >= 25) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_random_submit(40);
        sent += burst;
        burst = $urandom_range(1, 4);
        repeat (burst) send_random_complete();
        sent += burst;
      end else begin
        noise_mode = 2'($urandom_range(0, 3));
        send_item(noise_mode, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (noise_mode != MODE_UNUSED) sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    mode_i       <= MODE_SUBMIT;
    request_id_i <= '0;
    is_write_i   <= 1'b0;
    is_load_i    <= 1'b0;
    is_data_i    <= 1'b0;
    waiters.delete();
    grants_due.delete();
    holders      = '0;
    table_open   = 1'b0;
    fault_count  = 0;
    stall_cycles = 0;
    gaps_on      = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_ready();
    test_lock_handover();
    test_queue_full();
    test_random_traffic();
    test_reader_limit();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
